@@ hw/rtl/chbd_pkg.sv @@
// Package for the chunked body decoder: transfer structs, length constants,
// character classification and saturation helpers. No dependencies.
`timescale 1ns / 1ps

package chbd_pkg;

    // Internal length width; totals and chunk sizes saturate at its maximum.
    localparam int LEN_BITS = 32;
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
    localparam logic [63:0] LEN_MAX64 = 64'(LEN_MAX);

    localparam int OUT_LEN_BITS = 32;
    localparam int CFG_BITS = 32;

    // Configuration register indexes
    localparam logic CFG_CHUNKED_MODE   = 1'b0;
    localparam logic CFG_CONTENT_LENGTH = 1'b1;

    localparam logic [7:0] CH_LF = 8'h0A;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       begin_req;
    } t_in_item;

    typedef struct packed {
        logic [7:0]              payload_byte;
        logic                    has_data;
        logic                    body_end;
        logic [OUT_LEN_BITS-1:0] total_length;
        logic                    length_overflow;
    } t_out_item;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    // Space, tab, VT, FF, CR
    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
    endfunction

    // Clamp an internal total onto the 32-bit result field.
    function automatic logic [OUT_LEN_BITS-1:0] clamp_total(input logic [LEN_BITS-1:0] t);
        logic [63:0] t64;
        t64 = 64'(t);
        if (t64 > 64'hFFFF_FFFF) begin
            return {OUT_LEN_BITS{1'b1}};
        end
        return t64[OUT_LEN_BITS-1:0];
    endfunction

endpackage

@@ hw/rtl/http_chunked_body_decoder.sv @@
// Top level of the HTTP chunked body decoder: input register, decode core,
// result register. Depends on chbd_pkg, chbd_in_reg, chbd_core, chbd_out_reg.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                 Payload
// in        in   i_in_valid / o_in_ready   i_in  (data_byte, begin_req)
// out       out  o_out_valid / i_out_ready o_out (payload_byte, has_data, body_end,
//                                                 total_length, length_overflow)
// cfg       in   i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
// One body byte per cycle sustained while the output is not stalled. A byte
// is held in the input register, is decoded in the same cycle it leaves it,
// and its result (if any) shows on o_out the cycle after.
// Bytes that produce no result are simply consumed.
// Reset (synchronous, active low) clears both stage valids, the config
// registers and the decoder state (chunked size-line phase).
// A stalled output holds the input register; the input still takes one byte
// into an empty input register while a result waits.

module http_chunked_body_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [chbd_pkg::CFG_BITS-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  chbd_pkg::t_in_item            i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output chbd_pkg::t_out_item           o_out
);
    import chbd_pkg::*;

    logic      stg_valid;
    t_in_item  stg_item;
    logic      advance;
    logic      fire;
    logic      res_valid;
    t_out_item res;

    // A held byte is decoded when the result register can take its outcome
    assign fire = stg_valid && advance;

    chbd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in),
        .o_valid (stg_valid),
        .o_item  (stg_item),
        .i_take  (advance)
    );

    chbd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_item      (stg_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    chbd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_advance   (advance),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_item      (o_out)
    );

endmodule

@@ hw/rtl/chbd_in_reg.sv @@
// Input register stage of the chunked body decoder.
// Depends on chbd_pkg.
`timescale 1ns / 1ps

module chbd_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  chbd_pkg::t_in_item i_item,
    output logic              o_valid,
    output chbd_pkg::t_in_item o_item,
    input  logic              i_take
);
    import chbd_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // Free slot, or the held item moves on this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ hw/rtl/chbd_core.sv @@
// Decoder state and per-byte next-state logic; holds the config registers.
// Depends on chbd_pkg.
`timescale 1ns / 1ps

module chbd_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [chbd_pkg::CFG_BITS-1:0] i_cfg_data,
    input  logic                        i_fire,
    input  chbd_pkg::t_in_item          i_item,
    output logic                        o_res_valid,
    output chbd_pkg::t_out_item         o_res
);
    import chbd_pkg::*;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_DATA,
        PH_TAIL,
        PH_FINAL,
        PH_DONE,
        PH_FIXED
    } t_phase;

    logic                r_chunked_mode;
    logic [CFG_BITS-1:0] r_content_length;

    t_phase              r_phase,   n_phase;
    logic [LEN_BITS-1:0] r_size_acc, n_size_acc;
    logic                r_hex_stopped, n_hex_stopped;
    logic                r_hex_seen, n_hex_seen;
    logic [LEN_BITS-1:0] r_remaining, n_remaining;
    logic [LEN_BITS-1:0] r_total, n_total;
    logic                r_overflow, n_overflow;

    logic [7:0]          c;
    t_hex                hx;
    logic [63:0]         cl64;
    logic                cl_ovf;
    logic                emit, emit_data, emit_end;

    assign c    = i_item.data_byte;
    assign hx   = hex_decode(c);
    assign cl64 = 64'(r_content_length);
    assign cl_ovf = cl64 > LEN_MAX64;

    always_comb begin
        n_phase       = r_phase;
        n_size_acc    = r_size_acc;
        n_hex_stopped = r_hex_stopped;
        n_hex_seen    = r_hex_seen;
        n_remaining   = r_remaining;
        n_total       = r_total;
        n_overflow    = r_overflow;
        emit          = 1'b0;
        emit_data     = 1'b0;
        emit_end      = 1'b0;

        // New body: clear, sample config, then handle this byte
        if (i_item.begin_req) begin
            n_size_acc    = '0;
            n_hex_stopped = 1'b0;
            n_hex_seen    = 1'b0;
            n_total       = '0;
            n_overflow    = 1'b0;
            n_remaining   = '0;
            n_phase       = PH_SIZE;
            if (!r_chunked_mode) begin
                n_phase     = PH_FIXED;
                n_overflow  = cl_ovf;
                n_remaining = cl_ovf ? LEN_MAX : LEN_BITS'(cl64);
            end
        end

        case (n_phase)
            PH_SIZE: begin
                if (c == CH_LF) begin
                    n_hex_stopped = 1'b0;
                    n_hex_seen    = 1'b0;
                    if (n_size_acc == '0) begin
                        n_phase = PH_FINAL;
                    end else begin
                        n_remaining = n_size_acc;
                        n_size_acc  = '0;
                        n_phase     = PH_DATA;
                    end
                end else if (n_hex_stopped) begin
                    // rest of size line ignored
                end else if (!n_hex_seen && is_blank(c)) begin
                    // leading blank skipped
                end else if (!hx.valid) begin
                    n_hex_stopped = 1'b1;
                end else begin
                    n_hex_seen = 1'b1;
                    if (n_size_acc > (LEN_MAX >> 4)) begin
                        n_size_acc = LEN_MAX;
                        n_overflow = 1'b1;
                    end else begin
                        n_size_acc = {n_size_acc[LEN_BITS-5:0], hx.value};
                    end
                end
            end
            PH_DATA: begin
                if (n_total == LEN_MAX) begin
                    n_overflow = 1'b1;
                end else begin
                    n_total = n_total + 1'b1;
                end
                n_remaining = n_remaining - 1'b1;
                if (n_remaining == '0) begin
                    n_phase = PH_TAIL;
                end
                emit      = 1'b1;
                emit_data = 1'b1;
            end
            PH_TAIL: begin
                if (c == CH_LF) begin
                    n_phase = PH_SIZE;
                end
            end
            PH_FINAL: begin
                if (c == CH_LF) begin
                    n_phase  = PH_DONE;
                    emit     = 1'b1;
                    emit_end = 1'b1;
                end
            end
            PH_FIXED: begin
                emit = 1'b1;
                if (n_remaining == '0) begin
                    n_phase  = PH_DONE;
                    emit_end = 1'b1;
                end else begin
                    if (n_total == LEN_MAX) begin
                        n_overflow = 1'b1;
                    end else begin
                        n_total = n_total + 1'b1;
                    end
                    n_remaining = n_remaining - 1'b1;
                    emit_data   = 1'b1;
                    if (n_remaining == '0) begin
                        n_phase  = PH_DONE;
                        emit_end = 1'b1;
                    end
                end
            end
            default: begin
                // body finished: ignore until next begin_req
            end
        endcase
    end

    assign o_res_valid           = i_fire && emit;
    assign o_res.payload_byte    = emit_data ? c : 8'h00;
    assign o_res.has_data        = emit_data;
    assign o_res.body_end        = emit_end;
    assign o_res.total_length    = clamp_total(n_total);
    assign o_res.length_overflow = n_overflow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunked_mode   <= 1'b0;
            r_content_length <= '0;
            r_phase          <= PH_SIZE;
            r_size_acc       <= '0;
            r_hex_stopped    <= 1'b0;
            r_hex_seen       <= 1'b0;
            r_remaining      <= '0;
            r_total          <= '0;
            r_overflow       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CHUNKED_MODE:   r_chunked_mode   <= i_cfg_data[0];
                    CFG_CONTENT_LENGTH: r_content_length <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_fire) begin
                r_phase       <= n_phase;
                r_size_acc    <= n_size_acc;
                r_hex_stopped <= n_hex_stopped;
                r_hex_seen    <= n_hex_seen;
                r_remaining   <= n_remaining;
                r_total       <= n_total;
                r_overflow    <= n_overflow;
            end
        end
    end

endmodule

@@ hw/rtl/chbd_out_reg.sv @@
// Result register stage of the chunked body decoder.
// Depends on chbd_pkg.
`timescale 1ns / 1ps

module chbd_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    output logic                o_advance,
    input  logic                i_res_valid,
    input  chbd_pkg::t_out_item i_res,
    output logic                o_valid,
    input  logic                i_ready,
    output chbd_pkg::t_out_item o_item
);
    import chbd_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    // Register can take a new result when empty or being drained
    assign o_advance = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_res_valid) begin
            r_item <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ hw/rtl/chbd_checker.sv @@
// Port-level checks for the HTTP chunked body decoder, bound to the top level.
// Depends on chbd_pkg and http_chunked_body_decoder.
`timescale 1ns / 1ps

module chbd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input chbd_pkg::t_out_item o_out
);
    import chbd_pkg::*;

    // Nothing left in the result register after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Stalled result is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // Non-data results carry a zero byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.has_data |-> o_out.payload_byte == 8'h00)
        else $error("payload byte set without data");

    // A passed byte is already counted in the total
    a_total_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.has_data |-> o_out.total_length != '0)
        else $error("data result with zero total");

endmodule

bind http_chunked_body_decoder chbd_checker u_chbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

@@ verif/tb_top.sv @@
// Self-checking testbench for http_chunked_body_decoder: drives body bytes over a
// valid/ready channel and checks each result against a built-in decode predictor.
// Depends on chbd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;
    import chbd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          RAND_ITEMS  = 1150;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          HEX_BASE     = 16;
    localparam logic [7:0]  CH_CR        = 8'h0D;

    typedef logic [7:0] t_byte;

    // Decoder phases as the predictor tracks them
    typedef enum logic [2:0] {
        DEC_SIZE,
        DEC_DATA,
        DEC_TRAIL,
        DEC_FINAL,
        DEC_DONE,
        DEC_FIXED
    } t_dec_phase;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_idx;
    logic [CFG_BITS-1:0] i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    t_in_item            i_in;
    logic                o_out_valid;
    logic                i_out_ready;
    t_out_item           o_out;

    http_chunked_body_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the registers and the decoder
    // ------------------------------------------------------------------
    logic                cfg_chunked;
    logic [31:0]         cfg_len;
    t_dec_phase          dec_phase;
    logic [LEN_BITS-1:0] size_acc;
    logic                hex_stop;
    logic                hex_any;
    logic [LEN_BITS-1:0] remaining;
    logic [LEN_BITS-1:0] total;
    logic                ovf;

    t_in_item    pending_bytes[$];     // bytes waiting for the driver
    t_out_item   expected_decodes[$];  // predicted results, oldest first
    t_byte       body_q[$];            // scratch for building one body

    int          n_err;
    int          n_items;
    int          rand_base;
    int unsigned cycle_cnt;
    bit          in_taken;
    bit          in_steady;
    bit          out_steady;
    int          in_gap;
    int          out_stall;
    t_out_item   want;
    int          r_sel;
    int          n_act;
    logic [31:0] len_pick;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input t_byte c);
        t_byte lc;
        lc = c | 8'h20;
        if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
        if (lc >= 8'h61 && lc <= 8'h66) begin
            return {1'b1, 4'(lc - 8'h57)};
        end
        return 5'd0;
    endfunction

    function automatic bit blank_char(input t_byte c);
        case (c)
            8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic clear_decoder();
        dec_phase = DEC_SIZE;
        size_acc  = '0;
        hex_stop  = 1'b0;
        hex_any   = 1'b0;
        remaining = '0;
        total     = '0;
        ovf       = 1'b0;
    endtask

    task automatic count_payload();
        if (total >= LEN_MAX) ovf = 1'b1;
        else total = total + 1'b1;
    endtask

    task automatic push_result(input t_byte b, input bit is_data, input bit is_end);
        t_out_item   r;
        logic [63:0] tot64;
        tot64 = 64'(total);
        r.payload_byte    = is_data ? b : 8'h00;
        r.has_data        = is_data;
        r.body_end        = is_end;
        r.total_length    = (tot64 > 64'hFFFF_FFFF) ? {OUT_LEN_BITS{1'b1}}
                                                    : tot64[OUT_LEN_BITS-1:0];
        r.length_overflow = ovf;
        expected_decodes.insert(expected_decodes.size(), r);
    endtask

    // Advance the predictor by one accepted byte.
    task automatic decode_byte(input t_in_item it);
        t_byte      c;
        logic [4:0] hx;
        c  = it.data_byte;
        hx = hex_digit(c);
        // begin_req restarts the body and samples the registers first
        if (it.begin_req) begin
            clear_decoder();
            if (!cfg_chunked) begin
                dec_phase = DEC_FIXED;
                if (64'(cfg_len) > LEN_MAX64) begin
                    remaining = LEN_MAX;
                    ovf       = 1'b1;
                end else begin
                    remaining = LEN_BITS'(cfg_len);
                end
            end
        end
        case (dec_phase)
            DEC_SIZE: begin
                if (c == CH_LF) begin
                    hex_stop = 1'b0;
                    hex_any  = 1'b0;
                    if (size_acc == 0) begin
                        dec_phase = DEC_FINAL;
                    end else begin
                        remaining = size_acc;
                        size_acc  = '0;
                        dec_phase = DEC_DATA;
                    end
                end else if (!hex_stop && !(!hex_any && blank_char(c))) begin
                    if (!hx[4]) begin
                        hex_stop = 1'b1;
                    end else begin
                        hex_any = 1'b1;
                        // one more digit would not fit: pin at the maximum
                        if (size_acc > (LEN_MAX >> 4)) begin
                            size_acc = LEN_MAX;
                            ovf      = 1'b1;
                        end else begin
                            size_acc = LEN_BITS'(size_acc * HEX_BASE + hx[3:0]);
                        end
                    end
                end
            end
            DEC_DATA: begin
                count_payload();
                remaining = remaining - 1'b1;
                if (remaining == 0) dec_phase = DEC_TRAIL;
                push_result(c, 1'b1, 1'b0);
            end
            DEC_TRAIL: begin
                if (c == CH_LF) dec_phase = DEC_SIZE;
            end
            DEC_FINAL: begin
                if (c == CH_LF) begin
                    dec_phase = DEC_DONE;
                    push_result(8'h00, 1'b0, 1'b1);
                end
            end
            DEC_FIXED: begin
                if (remaining == 0) begin
                    // zero content length: end without passing the byte
                    dec_phase = DEC_DONE;
                    push_result(8'h00, 1'b0, 1'b1);
                end else begin
                    count_payload();
                    remaining = remaining - 1'b1;
                    if (remaining == 0) dec_phase = DEC_DONE;
                    push_result(c, 1'b1, remaining == 0);
                end
            end
            default: begin
                // body done: byte ignored until the next begin_req
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_byte hex_char(input logic [3:0] v);
        if (v < 10) return 8'h30 + v;
        return t_byte'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
    endfunction

    function automatic t_byte rand_blank();
        case ($urandom_range(0, 4))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0B;
            3: return 8'h0C;
            default: return CH_CR;
        endcase
    endfunction

    function automatic t_byte rand_non_lf();
        t_byte c;
        c = 8'($urandom);
        while (c == CH_LF) c = 8'($urandom);
        return c;
    endfunction

    // first character that ends the hex digits of a size line
    function automatic t_byte rand_nonhex();
        t_byte c;
        c = 8'($urandom);
        while (c == CH_LF || hex_digit(c) != 5'd0) c = 8'($urandom);
        return c;
    endfunction

    task automatic push_item(input t_byte b, input bit beg);
        t_in_item it;
        it.data_byte = b;
        it.begin_req = beg;
        pending_bytes.insert(pending_bytes.size(), it);
        n_items++;
    endtask

    task automatic push_text(input string s, input bit beg);
        for (int i = 0; i < s.len(); i++) push_item(t_byte'(s[i]), beg && i == 0);
    endtask

    // Append one byte to the body under construction.
    task automatic add_byte(input t_byte b);
        body_q.insert(body_q.size(), b);
    endtask

    // Rest of a line: optional junk, optional CR, then LF.
    task automatic add_line_end(input bit stop_hex);
        if ($urandom_range(0, 2) == 0) begin
            if (stop_hex) add_byte(rand_nonhex());
            repeat ($urandom_range(0, 3)) add_byte(rand_non_lf());
        end
        if ($urandom_range(0, 1)) add_byte(CH_CR);
        add_byte(CH_LF);
    endtask

    task automatic add_size_line(input logic [31:0] sz, input bit huge);
        int nd;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) add_byte(rand_blank());
        if (huge) begin
            // more digits than the length range holds
            add_byte(hex_char(4'($urandom_range(1, 15))));
            repeat ($urandom_range(8, 11)) add_byte(hex_char(4'($urandom_range(0, 15))));
        end else if (sz != 0 || $urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) add_byte(8'h30);
            nd = 1;
            for (int k = 1; k < 8; k++) if (sz[4*k +: 4] != 0) nd = k + 1;
            for (int k = nd - 1; k >= 0; k--) add_byte(hex_char(sz[4*k +: 4]));
        end
        // size zero with no digits at all is the empty / non-numeric line
        add_line_end(1'b1);
    endtask

    task automatic build_chunked(input bit huge);
        logic [31:0] sz;
        if (huge) begin
            add_size_line(32'd0, 1'b1);
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
        end else begin
            repeat ($urandom_range(0, 3)) begin
                sz = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 70);
                add_size_line(sz, 1'b0);
                repeat (sz) add_byte(8'($urandom));
                add_line_end(1'b0);
            end
            add_size_line(32'd0, 1'b0);
            add_line_end(1'b0);  // final line
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
        end
    endtask

    task automatic build_fixed();
        int n;
        n = (cfg_len <= 64) ? int'(cfg_len) : $urandom_range(1, 20);
        repeat (n) add_byte(8'($urandom));
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
    endtask

    // Queue the built body; a broken one may be cut short before its end.
    task automatic flush_body(input bit broken);
        int keep;
        if (body_q.size() == 0) add_byte(8'($urandom));
        keep = broken ? $urandom_range(1, body_q.size()) : body_q.size();
        for (int i = 0; i < keep; i++) push_item(body_q[i], i == 0);
        body_q.delete();
    endtask

    task automatic add_noise();
        t_byte b;
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 3))
                0: b = CH_LF;
                1: b = hex_char(4'($urandom_range(0, 15)));
                default: b = 8'($urandom);
            endcase
            push_item(b, $urandom_range(0, 9) == 0);
        end
    endtask

    // Registers change only at the falling edge while the decoder is idle.
    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_CHUNKED_MODE) cfg_chunked = val[0];
        else cfg_len = val;
    endtask

    task automatic set_config(input bit chunked, input logic [31:0] len);
        write_reg(CFG_CHUNKED_MODE, ($urandom & 32'hFFFF_FFFE) | 32'(chunked));
        write_reg(CFG_CONTENT_LENGTH, len);
    endtask

    // Hold the sender until all bytes are in and every result has come out,
    // then give the pipeline time to swallow bytes that make no result.
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || i_in_valid || expected_decodes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            n_err++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: one transfer per falling edge at most, gaps between bytes,
    // random stalls on the result side.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            // valid holds until the byte is taken
            if (!i_in_valid || in_taken) begin
                if (in_gap > 0) begin
                    in_gap = in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    i_in       <= pending_bytes.pop_front();
                    i_in_valid <= 1'b1;
                    if ($urandom_range(0, 149) == 0) in_steady = !in_steady;
                    in_gap = in_steady ? 0 : pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            in_taken = 1'b0;

            if (out_stall > 0) begin
                out_stall = out_stall - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 149) == 0) out_steady = !out_steady;
                if (!out_steady && $urandom_range(0, 3) == 0) out_stall = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transfer, feeds each input transfer to
    // the predictor.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_decodes.size() == 0) begin
                    $error("unexpected result: payload_byte %0h has_data %0b body_end %0b",
                           o_out.payload_byte, o_out.has_data, o_out.body_end);
                    n_err++;
                end else begin
                    want = expected_decodes.pop_front();
                    check_field("payload_byte", want.payload_byte, o_out.payload_byte);
                    check_field("has_data", want.has_data, o_out.has_data);
                    check_field("body_end", want.body_end, o_out.body_end);
                    check_field("total_length", want.total_length, o_out.total_length);
                    check_field("length_overflow", want.length_overflow, o_out.length_overflow);
                end
            end
            if (i_in_valid && o_in_ready) begin
                in_taken = 1'b1;
                decode_byte(i_in);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in       = '0;
        i_out_ready = 1'b0;
        cycle_cnt  = 0;
        n_err      = 0;
        n_items    = 0;
        n_act      = 0;
        in_taken   = 1'b0;
        in_steady  = 1'b0;
        out_steady = 1'b0;
        in_gap     = 0;
        out_stall  = 0;
        cfg_chunked = 1'b0;
        cfg_len     = '0;
        clear_decoder();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset, with no begin_req yet, the decoder sits in the chunked
        // size line even though fixed mode is selected.
        push_text("1\nZ\n\n\n", 1'b0);
        wait_idle();

        // Chunked: space, VT, FF and CR before the digits, a non-hex stop with junk
        // after it, then an empty size line and the final line.
        set_config(1'b1, 32'd0);
        push_item(8'h20, 1'b1);
        push_item(8'h0B, 1'b0);
        push_item(8'h0C, 1'b0);
        push_text("\r2zq\nAB\n\n\n", 1'b0);
        // Oversized chunk size saturates and flags overflow.
        push_text("FFFFFFFFF\n", 1'b1);
        push_item(8'hFF, 1'b0);
        wait_idle();

        // Fixed mode, zero length: one end-only result, then an ignored byte.
        set_config(1'b0, 32'd0);
        push_item(8'h00, 1'b1);
        push_item(8'h41, 1'b0);
        wait_idle();

        // Fixed mode, largest length.
        set_config(1'b0, 32'hFFFF_FFFF);
        push_item(8'hFF, 1'b1);
        push_item(8'h00, 1'b0);
        wait_idle();

        // Random phases: new settings each time the decoder is drained.
        rand_base = n_items;
        while (n_items - rand_base < RAND_ITEMS) begin
            wait_idle();
            r_sel = $urandom_range(0, 19);
            if (r_sel == 0) len_pick = 32'd0;
            else if (r_sel == 1) len_pick = 32'hFFFF_FFFF;
            else if (r_sel == 2) len_pick = $urandom;
            else len_pick = $urandom_range(0, 24);
            set_config($urandom_range(0, 99) < 65, len_pick);

            n_act = $urandom_range(4, 10);
            for (int k = 0; k < n_act && n_items - rand_base < RAND_ITEMS; k++) begin
                r_sel = $urandom_range(0, 99);
                if (r_sel < 80) begin
                    if (cfg_chunked) build_chunked(r_sel < 3);
                    else build_fixed();
                    flush_body(1'b0);
                end else if (r_sel < 90) begin
                    if (cfg_chunked) build_chunked(1'b0);
                    else build_fixed();
                    flush_body(1'b1);
                end else begin
                    add_noise();
                end
            end
        end

        wait_idle();
        if (expected_decodes.size() != 0) begin
            $error("%0d expected results never arrived", expected_decodes.size());
            n_err++;
        end
        if (n_err == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
